### src/rfli_pkg.sv
// rfli_pkg: shared types and constants for the random fern leaf index block
// used by rfli_ctrl, rfli_datapath and random_fern_leaf_index; no dependencies
package rfli_pkg;

    localparam int FERN_NUM_W   = 6;
    localparam int DEPTH_NUM_W  = 4;
    localparam int NODE_FEAT_W  = 8;
    localparam int VALUE_FIELD_W = 16;
    localparam int LEAF_W       = 17;
    localparam int CFG_COUNT_W  = 7;
    localparam int CFG_DEPTH_W  = 5;
    localparam int CFG_DATA_W   = 7;
    localparam int CFG_INDEX_W  = 1;

    localparam logic [CFG_INDEX_W-1:0] CFG_FERN_COUNT = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] CFG_FERN_DEPTH = 1'b1;

    localparam logic MODE_NODE    = 1'b0;
    localparam logic MODE_FEATURE = 1'b1;

    typedef struct packed {
        logic                            mode;
        logic [FERN_NUM_W-1:0]           fern_number;
        logic [DEPTH_NUM_W-1:0]          depth_number;
        logic [NODE_FEAT_W-1:0]          node_feature;
        logic signed [VALUE_FIELD_W-1:0] node_threshold;
        logic signed [VALUE_FIELD_W-1:0] feature_value;
        logic                            sample_last;
    } t_in_item;

    typedef struct packed {
        logic [FERN_NUM_W-1:0] fern_id;
        logic [LEAF_W-1:0]     leaf_index;
        logic                  result_last;
    } t_out_item;

    // controller to datapath
    typedef struct packed {
        logic start;
        logic issue;
        logic node_last;
        logic fern_last;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic fern_done;
        logic out_busy;
    } t_status;

endpackage

### src/rfli_ctrl.sv
// rfli_ctrl: sequencer for the fern walk, one node test issued per cycle
// within a fern; each fern waits for a free output; depends on rfli_pkg
module rfli_ctrl import rfli_pkg::*; #(
    parameter int MAX_FERNS = 64,
    parameter int MAX_DEPTH = 16,
    parameter int FW = (MAX_FERNS > 1) ? $clog2(MAX_FERNS) : 1,
    parameter int DW = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_accept,
    input  logic          i_in_mode,
    input  logic          i_in_last,
    input  logic [FW-1:0] i_nf_m1,
    input  logic [DW-1:0] i_nd_m1,
    input  t_status       i_status,
    output t_cmd          o_cmd,
    output logic          o_in_ready
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_WAIT,
        S_ISSUE,
        S_DRAIN
    } t_state;

    t_state        r_state;
    logic [FW-1:0] r_fern;
    logic [DW-1:0] r_depth;
    logic          r_start;
    logic          r_in_ready;
    logic          w_walk_go;

    assign w_walk_go = (r_state == S_IDLE) && i_in_accept
                    && (i_in_mode == MODE_FEATURE) && i_in_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_fern     <= '0;
            r_depth    <= '0;
            r_start    <= 1'b0;
            r_in_ready <= 1'b1;
        end else begin
            r_start <= w_walk_go;
            unique case (r_state)
                S_IDLE: begin
                    if (w_walk_go) begin
                        r_state    <= S_WAIT;
                        r_fern     <= '0;
                        r_in_ready <= 1'b0;
                    end
                end
                S_WAIT: begin
                    if (!i_status.out_busy) begin
                        r_state <= S_ISSUE;
                        r_depth <= '0;
                    end
                end
                S_ISSUE: begin
                    if (r_depth == i_nd_m1) begin
                        r_state <= S_DRAIN;
                    end else begin
                        r_depth <= r_depth + 1'b1;
                    end
                end
                S_DRAIN: begin
                    if (i_status.fern_done) begin
                        if (r_fern == i_nf_m1) begin
                            r_state    <= S_IDLE;
                            r_in_ready <= 1'b1;
                        end else begin
                            r_fern  <= r_fern + 1'b1;
                            r_state <= S_WAIT;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    always_comb begin
        o_cmd.start     = r_start;
        o_cmd.issue     = (r_state == S_ISSUE);
        o_cmd.node_last = (r_depth == i_nd_m1);
        o_cmd.fern_last = (r_fern == i_nf_m1);
    end

    assign o_in_ready = r_in_ready;

    a_issue_out_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.issue |-> !i_status.out_busy)
        else $error("node issued while output register is blocked");

    a_walk_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ISSUE || r_state == S_DRAIN) |-> !r_in_ready)
        else $error("input ready during fern walk");

endmodule

### src/rfli_datapath.sv
// rfli_datapath: node and feature memories, three-stage test pipeline, result register
// depends on rfli_pkg
module rfli_datapath import rfli_pkg::*; #(
    parameter int MAX_FEATURES = 256,
    parameter int MAX_FERNS    = 64,
    parameter int MAX_DEPTH    = 16,
    parameter int VALUE_WIDTH  = 16
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_accept,
    input  t_in_item  i_in_item,
    input  t_cmd      i_cmd,
    output t_status   o_status,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out_item
);

    localparam int NODE_DEPTH = MAX_FERNS * MAX_DEPTH;
    localparam int AW  = (NODE_DEPTH > 1) ? $clog2(NODE_DEPTH) : 1;
    localparam int FAW = $clog2(MAX_FEATURES);

    typedef struct packed {
        logic [NODE_FEAT_W-1:0]        feature;
        logic signed [VALUE_WIDTH-1:0] threshold;
    } t_node;

    t_node                         node_mem [NODE_DEPTH];
    logic signed [VALUE_WIDTH-1:0] feat_mem [MAX_FEATURES];

    logic [FAW-1:0]                r_wr_ptr;
    logic [AW-1:0]                 r_node_addr;
    logic [AW-1:0]                 r_base;
    logic                          r_s1_valid;
    logic                          r_s1_node_last;
    logic                          r_s1_fern_last;
    t_node                         r_node_q;
    logic                          r_s2_valid;
    logic                          r_s2_node_last;
    logic                          r_s2_fern_last;
    logic                          r_s2_in_range;
    logic signed [VALUE_WIDTH-1:0] r_s2_thr;
    logic signed [VALUE_WIDTH-1:0] r_feat_q;
    logic [LEAF_W-1:0]             r_acc;
    logic [FERN_NUM_W-1:0]         r_fern_id;
    logic                          r_out_valid;
    t_out_item                     r_out;

    logic [31:0]                   w_node_slot;
    logic                          w_node_ok;
    logic [31:0]                   w_val_ext;
    logic [31:0]                   w_thr_ext;
    logic [31:0]                   w_feat_ext;
    logic                          w_feat_ok;
    logic signed [VALUE_WIDTH-1:0] w_x;
    logic                          w_bit;
    logic [LEAF_W-1:0]             w_acc_next;
    logic                          w_emit;
    logic                          w_out_busy;

    // node slot and range check
    assign w_node_slot = 32'(i_in_item.fern_number) * 32'(MAX_DEPTH)
                       + 32'(i_in_item.depth_number);
    assign w_node_ok   = (32'(i_in_item.fern_number) < 32'(MAX_FERNS))
                      && (32'(i_in_item.depth_number) < 32'(MAX_DEPTH));
    assign w_val_ext   = {{(32-VALUE_FIELD_W){1'b0}}, i_in_item.feature_value};
    assign w_thr_ext   = {{(32-VALUE_FIELD_W){1'b0}}, i_in_item.node_threshold};

    always_ff @(posedge i_clk) begin
        if (i_in_accept && i_in_item.mode == MODE_NODE && w_node_ok) begin
            node_mem[w_node_slot[AW-1:0]] <= '{feature:   i_in_item.node_feature,
                                               threshold: w_thr_ext[VALUE_WIDTH-1:0]};
        end
        if (i_cmd.issue) begin
            r_node_q <= node_mem[r_node_addr];
        end
    end

    // feature buffer
    assign w_feat_ext = {{(32-NODE_FEAT_W){1'b0}}, r_node_q.feature};
    assign w_feat_ok  = w_feat_ext < 32'(MAX_FEATURES);

    always_ff @(posedge i_clk) begin
        if (i_in_accept && i_in_item.mode == MODE_FEATURE) begin
            feat_mem[r_wr_ptr] <= w_val_ext[VALUE_WIDTH-1:0];
        end
        if (r_s1_valid) begin
            r_feat_q <= feat_mem[w_feat_ext[FAW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
        end else if (i_in_accept && i_in_item.mode == MODE_FEATURE) begin
            if (i_in_item.sample_last || r_wr_ptr == FAW'(MAX_FEATURES - 1)) begin
                r_wr_ptr <= '0;
            end else begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
        end
    end

    // test and accumulate
    assign w_x        = r_s2_in_range ? r_feat_q : '0;
    assign w_bit      = (w_x < r_s2_thr);
    assign w_acc_next = {r_acc[LEAF_W-2:0], w_bit};
    assign w_emit     = r_s2_valid && r_s2_node_last;
    assign w_out_busy = r_out_valid && !i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_node_addr <= '0;
            r_base      <= '0;
            r_s1_valid  <= 1'b0;
            r_s2_valid  <= 1'b0;
            r_acc       <= '0;
            r_fern_id   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_s1_valid <= i_cmd.issue;
            r_s2_valid <= r_s1_valid;
            if (i_cmd.start) begin
                r_node_addr <= '0;
                r_base      <= '0;
                r_acc       <= '0;
                r_fern_id   <= '0;
            end else if (i_cmd.issue) begin
                if (i_cmd.node_last) begin
                    r_base      <= r_base + AW'(MAX_DEPTH);
                    r_node_addr <= r_base + AW'(MAX_DEPTH);
                end else begin
                    r_node_addr <= r_node_addr + 1'b1;
                end
            end
            if (r_s2_valid) begin
                r_acc <= w_emit ? '0 : w_acc_next;
            end
            if (w_emit) begin
                r_fern_id   <= r_fern_id + 1'b1;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_node_last <= i_cmd.node_last;
        r_s1_fern_last <= i_cmd.fern_last;
        r_s2_node_last <= r_s1_node_last;
        r_s2_fern_last <= r_s1_fern_last;
        r_s2_in_range  <= w_feat_ok;
        r_s2_thr       <= r_node_q.threshold;
        if (w_emit) begin
            r_out.fern_id     <= r_fern_id;
            r_out.leaf_index  <= w_acc_next + 1'b1;
            r_out.result_last <= r_s2_fern_last;
        end
    end

    assign o_status.fern_done = w_emit;
    assign o_status.out_busy  = w_out_busy;
    assign o_out_valid        = r_out_valid;
    assign o_out_item         = r_out;

    a_emit_slot_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_emit |-> !w_out_busy)
        else $error("result overwrites an item not yet taken");

    a_no_input_in_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_accept |-> (!r_s1_valid && !r_s2_valid))
        else $error("item accepted while node tests are in flight");

endmodule

### src/random_fern_leaf_index.sv
// random_fern_leaf_index: node and feature items are taken one item per cycle while input is
// ready; a last feature item starts a walk: one node test per cycle within each fern, through
// node memory, feature memory and compare; each fern waits while a result is not yet taken;
// input is held off until the last fern of the walk is done
// synchronous active-low reset: fern_count 1, fern_depth 1, feature pointer 0; memories
// hold no reset value and are defined once written
module random_fern_leaf_index import rfli_pkg::*; #(
    parameter int MAX_FEATURES = 256,
    parameter int MAX_FERNS    = 64,
    parameter int MAX_DEPTH    = 16,
    parameter int VALUE_WIDTH  = 16
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_we,
    input  logic [CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data,
    input  logic                   i_in_valid,
    output logic                   o_in_ready,
    input  t_in_item               i_in_item,
    output logic                   o_out_valid,
    input  logic                   i_out_ready,
    output t_out_item              o_out_item
);

    localparam int FW = (MAX_FERNS > 1) ? $clog2(MAX_FERNS) : 1;
    localparam int DW = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;

    logic [CFG_COUNT_W-1:0] r_fern_count;
    logic [CFG_DEPTH_W-1:0] r_fern_depth;
    logic [FW-1:0]          w_nf_m1;
    logic [DW-1:0]          w_nd_m1;
    logic                   w_in_accept;
    t_cmd                   w_cmd;
    t_status                w_status;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fern_count <= CFG_COUNT_W'(1);
            r_fern_depth <= CFG_DEPTH_W'(1);
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_FERN_COUNT: r_fern_count <= i_cfg_data[CFG_COUNT_W-1:0];
                CFG_FERN_DEPTH: r_fern_depth <= i_cfg_data[CFG_DEPTH_W-1:0];
                default: ;
            endcase
        end
    end

    // clamp to the built sizes
    always_comb begin
        if (r_fern_count == '0) begin
            w_nf_m1 = '0;
        end else if (32'(r_fern_count) > 32'(MAX_FERNS)) begin
            w_nf_m1 = FW'(MAX_FERNS - 1);
        end else begin
            w_nf_m1 = FW'(r_fern_count - 1'b1);
        end
        if (r_fern_depth == '0) begin
            w_nd_m1 = '0;
        end else if (32'(r_fern_depth) > 32'(MAX_DEPTH)) begin
            w_nd_m1 = DW'(MAX_DEPTH - 1);
        end else begin
            w_nd_m1 = DW'(r_fern_depth - 1'b1);
        end
    end

    assign w_in_accept = i_in_valid && o_in_ready;

    rfli_ctrl #(
        .MAX_FERNS (MAX_FERNS),
        .MAX_DEPTH (MAX_DEPTH),
        .FW        (FW),
        .DW        (DW)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_accept (w_in_accept),
        .i_in_mode   (i_in_item.mode),
        .i_in_last   (i_in_item.sample_last),
        .i_nf_m1     (w_nf_m1),
        .i_nd_m1     (w_nd_m1),
        .i_status    (w_status),
        .o_cmd       (w_cmd),
        .o_in_ready  (o_in_ready)
    );

    rfli_datapath #(
        .MAX_FEATURES (MAX_FEATURES),
        .MAX_FERNS    (MAX_FERNS),
        .MAX_DEPTH    (MAX_DEPTH),
        .VALUE_WIDTH  (VALUE_WIDTH)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_accept (w_in_accept),
        .i_in_item   (i_in_item),
        .i_cmd       (w_cmd),
        .o_status    (w_status),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item)
    );

endmodule
